// ----- sv/ps2ma_pkg.sv -----
// Shared opcodes, bit positions, widths and control types for the mouse packet assembler.
package ps2ma_pkg;

    localparam int ACC_WIDTH_DEF = 16;
    localparam int OUT_WIDTH     = 16;
    localparam int DELTA_WIDTH   = 9;

    localparam logic [1:0] OP_DATA  = 2'd0;
    localparam logic [1:0] OP_FETCH = 2'd1;
    localparam logic [1:0] OP_TAKE  = 2'd2;

    localparam int SYNC_BIT   = 3;
    localparam int XOVF_BIT   = 6;
    localparam int YOVF_BIT   = 7;
    localparam int BTN_LEFT   = 0;
    localparam int BTN_RIGHT  = 1;
    localparam int BTN_MIDDLE = 2;

    localparam logic signed [OUT_WIDTH-1:0] OUT_MAX = 16'sh7FFF;
    localparam logic signed [OUT_WIDTH-1:0] OUT_MIN = 16'sh8000;

    typedef struct packed {
        logic add_en;
        logic clear_en;
    } acc_ctrl_t;

endpackage

// ----- sv/ps2_mouse_packet_assembler.sv -----
// Top level: PS/2 mouse three-byte packet framing, delta accumulation and request handling.
// Takes one request per cycle unless a result stalls: an item enters an input register, is decoded
// against the framing and accumulator state by combinational logic, and a fetch or take lands in an
// output register while the next item is already accepted. A stalled result holds the item that
// needs the output and every item behind it. Throughput is one item per clock while no result
// stalls; a result passes the input register, then the output register. Bytes with a link error
// restart framing; a first byte without the sync bit is dropped; overflowed axes are not added.
module ps2_mouse_packet_assembler
    import ps2ma_pkg::*;
#(
    parameter int ACC_WIDTH = ACC_WIDTH_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [1:0]                  s_opcode,
    input  logic [7:0]                  s_byte_value,
    input  logic                        s_link_error,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic signed [OUT_WIDTH-1:0] m_delta_x_out,
    output logic signed [OUT_WIDTH-1:0] m_delta_y_out,
    output logic [2:0]                  m_buttons_out,
    output logic                        m_packet_valid,
    output logic [7:0]                  m_packet_flags,
    output logic signed [7:0]           m_packet_x,
    output logic signed [7:0]           m_packet_y
);

    // input register
    logic       in_valid_reg;
    logic [1:0] in_opcode_reg;
    logic [7:0] in_byte_reg;
    logic       in_err_reg;

    // framing state
    logic [7:0] bytes_reg [3];
    logic [7:0] bytes_next [3];
    logic [1:0] index_reg, index_next;
    logic [2:0] buttons_reg, buttons_next;
    logic       ready_reg, ready_next;

    // output register
    logic                        out_valid_reg;
    logic signed [OUT_WIDTH-1:0] out_dx_reg, out_dy_reg;
    logic [2:0]                  out_buttons_reg;
    logic                        out_pvalid_reg;
    logic [7:0]                  out_flags_reg, out_x_reg, out_y_reg;

    logic signed [OUT_WIDTH-1:0] res_dx, res_dy;
    logic [2:0]                  res_buttons;
    logic                        res_pvalid;
    logic [7:0]                  res_flags, res_x, res_y;

    logic       has_result;
    logic       advance;
    logic [1:0] index_eff;

    acc_ctrl_t                     ctrl_x, ctrl_y;
    logic signed [DELTA_WIDTH-1:0] delta_x, delta_y;
    logic signed [OUT_WIDTH-1:0]   clamp_x, clamp_y;

    assign has_result = in_valid_reg
                      && ((in_opcode_reg == OP_FETCH) || (in_opcode_reg == OP_TAKE));
    assign advance    = in_valid_reg && (!has_result || !out_valid_reg || m_ready);
    assign s_ready    = !in_valid_reg || advance;

    assign index_eff = (index_reg > 2'd2) ? 2'd0 : index_reg;
    assign delta_x   = DELTA_WIDTH'(signed'(bytes_reg[1]));
    assign delta_y   = -DELTA_WIDTH'(signed'(in_byte_reg));

    always_comb begin
        bytes_next   = bytes_reg;
        index_next   = index_reg;
        buttons_next = buttons_reg;
        ready_next   = ready_reg;
        ctrl_x       = '0;
        ctrl_y       = '0;
        res_dx       = '0;
        res_dy       = '0;
        res_buttons  = '0;
        res_pvalid   = 1'b0;
        res_flags    = '0;
        res_x        = '0;
        res_y        = '0;
        if (advance) begin
            case (in_opcode_reg)
                OP_DATA: begin
                    if (in_err_reg) begin
                        index_next = 2'd0;
                    end else if (index_eff == 2'd0 && !in_byte_reg[SYNC_BIT]) begin
                        index_next = index_eff;
                    end else begin
                        bytes_next[index_eff] = in_byte_reg;
                        index_next = index_eff + 2'd1;
                        if (index_eff == 2'd2) begin
                            index_next = 2'd0;
                            ready_next = 1'b1;
                            buttons_next[BTN_LEFT]   = bytes_reg[0][BTN_LEFT];
                            buttons_next[BTN_RIGHT]  = bytes_reg[0][BTN_RIGHT];
                            buttons_next[BTN_MIDDLE] = bytes_reg[0][BTN_MIDDLE];
                            ctrl_x.add_en = !bytes_reg[0][XOVF_BIT];
                            ctrl_y.add_en = !bytes_reg[0][YOVF_BIT];
                        end
                    end
                end
                OP_FETCH: begin
                    res_dx          = clamp_x;
                    res_dy          = clamp_y;
                    res_buttons     = buttons_reg;
                    ctrl_x.clear_en = 1'b1;
                    ctrl_y.clear_en = 1'b1;
                end
                OP_TAKE: begin
                    if (ready_reg) begin
                        res_buttons = buttons_reg;
                        res_pvalid  = 1'b1;
                        res_flags   = bytes_reg[0];
                        res_x       = bytes_reg[1];
                        res_y       = bytes_reg[2];
                        ready_next  = 1'b0;
                    end
                end
                default: begin
                    // ignored opcode: drop
                end
            endcase
        end
    end

    ps2ma_accum #(.ACC_WIDTH(ACC_WIDTH)) u_accum_x (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (ctrl_x),
        .delta     (delta_x),
        .clamp_out (clamp_x)
    );

    ps2ma_accum #(.ACC_WIDTH(ACC_WIDTH)) u_accum_y (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (ctrl_y),
        .delta     (delta_y),
        .clamp_out (clamp_y)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            bytes_reg[0]  <= '0;
            bytes_reg[1]  <= '0;
            bytes_reg[2]  <= '0;
            index_reg     <= '0;
            buttons_reg   <= '0;
            ready_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            bytes_reg   <= bytes_next;
            index_reg   <= index_next;
            buttons_reg <= buttons_next;
            ready_reg   <= ready_next;
            if (advance && has_result) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_opcode_reg <= s_opcode;
            in_byte_reg   <= s_byte_value;
            in_err_reg    <= s_link_error;
        end
        if (advance && has_result) begin
            out_dx_reg      <= res_dx;
            out_dy_reg      <= res_dy;
            out_buttons_reg <= res_buttons;
            out_pvalid_reg  <= res_pvalid;
            out_flags_reg   <= res_flags;
            out_x_reg       <= res_x;
            out_y_reg       <= res_y;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_delta_x_out  = out_dx_reg;
    assign m_delta_y_out  = out_dy_reg;
    assign m_buttons_out  = out_buttons_reg;
    assign m_packet_valid = out_pvalid_reg;
    assign m_packet_flags = out_flags_reg;
    assign m_packet_x     = signed'(out_x_reg);
    assign m_packet_y     = signed'(out_y_reg);

endmodule

// ----- sv/ps2ma_accum.sv -----
// Saturating movement accumulator with clear and a 16-bit clamped view.
module ps2ma_accum
    import ps2ma_pkg::*;
#(
    parameter int ACC_WIDTH = ACC_WIDTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  acc_ctrl_t                     ctrl,
    input  logic signed [DELTA_WIDTH-1:0] delta,
    output logic signed [OUT_WIDTH-1:0]   clamp_out
);

    localparam int SUM_WIDTH = ACC_WIDTH + 1;
    localparam logic signed [ACC_WIDTH-1:0] ACC_MAX = {1'b0, {(ACC_WIDTH-1){1'b1}}};
    localparam logic signed [ACC_WIDTH-1:0] ACC_MIN = {1'b1, {(ACC_WIDTH-1){1'b0}}};

    logic signed [ACC_WIDTH-1:0] acc_reg;
    logic signed [ACC_WIDTH-1:0] acc_next;
    logic signed [SUM_WIDTH-1:0] sum;
    logic signed [ACC_WIDTH-1:0] sum_sat;

    always_comb begin
        sum = SUM_WIDTH'(acc_reg) + SUM_WIDTH'(delta);
        // top two bits disagree: the add left the accumulator range
        if (sum[SUM_WIDTH-1] != sum[SUM_WIDTH-2]) begin
            sum_sat = sum[SUM_WIDTH-1] ? ACC_MIN : ACC_MAX;
        end else begin
            sum_sat = sum[ACC_WIDTH-1:0];
        end
    end

    always_comb begin
        acc_next = acc_reg;
        if (ctrl.clear_en) begin
            acc_next = '0;
        end else if (ctrl.add_en) begin
            acc_next = sum_sat;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg <= '0;
        end else begin
            acc_reg <= acc_next;
        end
    end

    generate
        if (ACC_WIDTH <= OUT_WIDTH) begin : g_extend
            assign clamp_out = OUT_WIDTH'(acc_reg);
        end else begin : g_clamp
            logic hi_same;
            assign hi_same = (&acc_reg[ACC_WIDTH-1:OUT_WIDTH-1])
                           | ~(|acc_reg[ACC_WIDTH-1:OUT_WIDTH-1]);
            assign clamp_out = hi_same ? acc_reg[OUT_WIDTH-1:0]
                             : (acc_reg[ACC_WIDTH-1] ? OUT_MIN : OUT_MAX);
        end
    endgenerate

endmodule
